### sv/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants of the Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int IDX_W     = 13;  // pixel column / row width
    localparam int ITER_W    = 16;  // iteration count port width
    localparam int Q_W       = 32;  // Q4.28 word
    localparam int STEP_W    = 31;
    localparam int ESC_W     = 4;
    localparam int FRAC_BITS = 28;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam logic [2:0] REG_RE_ORIGIN = 3'd0;
    localparam logic [2:0] REG_IM_ORIGIN = 3'd1;
    localparam logic [2:0] REG_RE_STEP   = 3'd2;
    localparam logic [2:0] REG_IM_STEP   = 3'd3;
    localparam logic [2:0] REG_MAX_ITER  = 3'd4;
    localparam logic [2:0] REG_ESC_LIMIT = 3'd5;

    typedef struct packed {
        logic signed [Q_W-1:0] re_origin;
        logic signed [Q_W-1:0] im_origin;
        logic [STEP_W-1:0]     re_step;
        logic [STEP_W-1:0]     im_step;
        logic [ITER_W-1:0]     max_iter;
        logic [ESC_W-1:0]      escape_limit;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
    } red_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MAP_RE,
        ST_MAP_IM,
        ST_MAP_END,
        ST_SQR_R,
        ST_SQR_I,
        ST_CROSS,
        ST_UPD,
        ST_DONE
    } state_t;

endpackage

### sv/mbe_regs.sv
// ----------------------------------------------------------------------------
// mbe_regs
// APB configuration registers: origin, step, iteration limit, escape bound.
// ----------------------------------------------------------------------------
module mbe_regs
    import mbe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg_o
);

    cfg_t        cfg_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg_o   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.re_origin    <= 32'shE000_0000;
            cfg_reg.im_origin    <= 32'shE000_0000;
            cfg_reg.re_step      <= 31'd214748;
            cfg_reg.im_step      <= 31'd214748;
            cfg_reg.max_iter     <= 16'd200;
            cfg_reg.escape_limit <= 4'd4;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RE_ORIGIN: cfg_reg.re_origin    <= pwdata;
                REG_IM_ORIGIN: cfg_reg.im_origin    <= pwdata;
                REG_RE_STEP:   cfg_reg.re_step      <= pwdata[STEP_W-1:0];
                REG_IM_STEP:   cfg_reg.im_step      <= pwdata[STEP_W-1:0];
                REG_MAX_ITER:  cfg_reg.max_iter     <= pwdata[ITER_W-1:0];
                REG_ESC_LIMIT: cfg_reg.escape_limit <= pwdata[ESC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RE_ORIGIN: prdata = cfg_reg.re_origin;
            REG_IM_ORIGIN: prdata = cfg_reg.im_origin;
            REG_RE_STEP:   prdata = {1'b0, cfg_reg.re_step};
            REG_IM_STEP:   prdata = {1'b0, cfg_reg.im_step};
            REG_MAX_ITER:  prdata = {16'd0, cfg_reg.max_iter};
            REG_ESC_LIMIT: prdata = {28'd0, cfg_reg.escape_limit};
            default:       prdata = '0;
        endcase
    end

endmodule

### sv/mbe_dimred.sv
// ----------------------------------------------------------------------------
// mbe_dimred
// Remainder of a pixel index modulo the picture dimension, by reciprocal
// multiplication over two steps.
// ----------------------------------------------------------------------------
module mbe_dimred
    import mbe_pkg::*;
#(
    parameter int MAX_DIM = 8192
) (
    input  logic             aclk,
    input  red_ctrl_t        ctrl_i,
    input  logic [IDX_W-1:0] value_i,
    output logic [IDX_W-1:0] rem_o
);

    // floor(x * RECIP / 2^SHIFT) is the exact quotient for every IDX_W-bit x
    localparam int                 SHIFT   = IDX_W + $clog2(MAX_DIM);
    localparam int                 RECIP_W = IDX_W + 2;
    localparam longint             RECIP   = ((longint'(1) << SHIFT) + longint'(MAX_DIM) - 1)
                                             / longint'(MAX_DIM);
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [IDX_W-1:0]   DIM_LO  = IDX_W'(MAX_DIM);

    logic [IDX_W-1:0]         value_reg;
    logic [IDX_W-1:0]         quot_reg;
    logic [IDX_W-1:0]         rem_reg;
    logic [IDX_W+RECIP_W-1:0] scaled;
    logic [2*IDX_W-1:0]       back;

    assign scaled = value_reg * RECIP_C;
    assign back   = quot_reg * DIM_LO;
    assign rem_o  = rem_reg;

    // first step forms the quotient, second the remainder
    always_ff @(posedge aclk) begin
        if (ctrl_i.load) begin
            value_reg <= value_i;
        end else if (ctrl_i.step) begin
            quot_reg <= IDX_W'(scaled >> SHIFT);
            rem_reg  <= value_reg - back[IDX_W-1:0];
        end
    end

endmodule

### sv/mbe_mul.sv
// ----------------------------------------------------------------------------
// mbe_mul
// Shared signed 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
module mbe_mul
    import mbe_pkg::*;
(
    input  logic                    aclk,
    input  logic signed [Q_W-1:0]   a_i,
    input  logic signed [Q_W-1:0]   b_i,
    output logic signed [2*Q_W-1:0] p_o
);

    logic signed [2*Q_W-1:0] p_reg;

    assign p_o = p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a_i * b_i;
    end

endmodule

### sv/mbe_core.sv
// ----------------------------------------------------------------------------
// mbe_core
// Sequencer: index reduction, point mapping and the z = z*z + c loop,
// all mapping and loop products through one shared multiplier.
// ----------------------------------------------------------------------------
module mbe_core
    import mbe_pkg::*;
#(
    parameter int MAX_DIM   = 8192,
    parameter int ITER_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg_i,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [IDX_W-1:0]  s_col,
    input  logic [IDX_W-1:0]  s_row,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ITER_W-1:0] m_iterations
);

    localparam int CNT_W      = (ITER_BITS < ITER_W) ? ITER_BITS : ITER_W;
    localparam int RED_CYCLES = 2;
    localparam int RCNT_W     = $clog2(RED_CYCLES);
    localparam logic [RCNT_W-1:0] RED_LAST = RCNT_W'(RED_CYCLES - 1);
    localparam int SUM_W      = 48;

    typedef struct packed {
        logic signed [Q_W-1:0] q;
        logic                  over;
    } sat_t;

    function automatic sat_t sat_q(input logic signed [SUM_W-1:0] v);
        sat_t r;
        r.over = 1'b0;
        r.q    = v[Q_W-1:0];
        if (v[SUM_W-1] && !(&v[SUM_W-2:Q_W-1])) begin
            r.over = 1'b1;
            r.q    = {1'b1, {(Q_W-1){1'b0}}};
        end else if (!v[SUM_W-1] && (|v[SUM_W-2:Q_W-1])) begin
            r.over = 1'b1;
            r.q    = {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

    state_t                  state_reg, state_next;
    logic [RCNT_W-1:0]       red_cnt_reg, red_cnt_next;
    logic signed [Q_W-1:0]   cre_reg, cre_next;
    logic signed [Q_W-1:0]   cim_reg, cim_next;
    logic signed [Q_W-1:0]   zr_reg, zr_next;
    logic signed [Q_W-1:0]   zi_reg, zi_next;
    logic signed [2*Q_W-1:0] rr_reg, rr_next;
    logic signed [2*Q_W-1:0] diff_reg, diff_next;
    logic                    over_reg, over_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    m_valid_reg, m_valid_next;
    logic [ITER_W-1:0]       m_iter_reg, m_iter_next;

    red_ctrl_t               red_ctrl;
    logic [IDX_W-1:0]        col_mod, row_mod;
    logic signed [Q_W-1:0]   mul_a, mul_b;
    logic signed [2*Q_W-1:0] prod;

    logic [2*Q_W-1:0]        norm, bound;
    logic [CNT_W-1:0]        limit;
    logic                    keep, out_free;
    logic signed [SUM_W-1:0] map_sum, upd_re_sum, upd_im_sum;
    sat_t                    sat_map, sat_re, sat_im;

    mbe_dimred #(.MAX_DIM(MAX_DIM)) u_red_col (
        .aclk    (aclk),
        .ctrl_i  (red_ctrl),
        .value_i (s_col),
        .rem_o   (col_mod)
    );

    mbe_dimred #(.MAX_DIM(MAX_DIM)) u_red_row (
        .aclk    (aclk),
        .ctrl_i  (red_ctrl),
        .value_i (s_row),
        .rem_o   (row_mod)
    );

    mbe_mul u_mul (
        .aclk (aclk),
        .a_i  (mul_a),
        .b_i  (mul_b),
        .p_o  (prod)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_iterations = m_iter_reg;

    assign limit    = cfg_i.max_iter[CNT_W-1:0];
    assign bound    = {4'd0, cfg_i.escape_limit, 56'd0};
    assign norm     = $unsigned(rr_reg) + $unsigned(prod);
    assign keep     = (count_reg < limit) && !over_reg && (norm < bound);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        if (state_reg == ST_MAP_IM) begin
            map_sum = {{(SUM_W-Q_W){cfg_i.re_origin[Q_W-1]}}, cfg_i.re_origin}
                    + {4'd0, prod[43:0]};
        end else begin
            map_sum = {{(SUM_W-Q_W){cfg_i.im_origin[Q_W-1]}}, cfg_i.im_origin}
                    + {4'd0, prod[43:0]};
        end
        upd_re_sum = {{12{diff_reg[2*Q_W-1]}}, diff_reg[2*Q_W-1:FRAC_BITS]}
                   + {{(SUM_W-Q_W){cre_reg[Q_W-1]}}, cre_reg};
        upd_im_sum = {{11{prod[2*Q_W-1]}}, prod[2*Q_W-1:FRAC_BITS-1]}
                   + {{(SUM_W-Q_W){cim_reg[Q_W-1]}}, cim_reg};
        sat_map = sat_q(map_sum);
        sat_re  = sat_q(upd_re_sum);
        sat_im  = sat_q(upd_im_sum);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (red_cnt_reg == RED_LAST) begin
                    state_next = ST_MAP_RE;
                end
            end
            ST_MAP_RE:  state_next = ST_MAP_IM;
            ST_MAP_IM:  state_next = ST_MAP_END;
            ST_MAP_END: state_next = ST_SQR_R;
            ST_SQR_R:   state_next = ST_SQR_I;
            ST_SQR_I:   state_next = ST_CROSS;
            ST_CROSS: begin
                if (count_reg == '0 || keep) begin
                    state_next = ST_UPD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_UPD:     state_next = ST_SQR_R;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        red_ctrl      = '0;
        mul_a         = zr_reg;
        mul_b         = zr_reg;
        red_cnt_next  = red_cnt_reg;
        cre_next      = cre_reg;
        cim_next      = cim_reg;
        zr_next       = zr_reg;
        zi_next       = zi_reg;
        rr_next       = rr_reg;
        diff_next     = diff_reg;
        over_next     = over_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_iter_next   = m_iter_reg;
        case (state_reg)
            ST_IDLE: begin
                red_ctrl.load = s_valid;
                red_cnt_next  = '0;
            end
            ST_REDUCE: begin
                red_ctrl.step = 1'b1;
                red_cnt_next  = red_cnt_reg + 1'b1;
            end
            ST_MAP_RE: begin
                mul_a = {{(Q_W-IDX_W){1'b0}}, col_mod};
                mul_b = {1'b0, cfg_i.re_step};
            end
            ST_MAP_IM: begin
                mul_a    = {{(Q_W-IDX_W){1'b0}}, row_mod};
                mul_b    = {1'b0, cfg_i.im_step};
                cre_next = sat_map.q;
            end
            ST_MAP_END: begin
                cim_next   = sat_map.q;
                zr_next    = '0;
                zi_next    = '0;
                over_next  = 1'b0;
                count_next = '0;
            end
            ST_SQR_R: begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            ST_SQR_I: begin
                mul_a   = zi_reg;
                mul_b   = zi_reg;
                rr_next = prod;
            end
            ST_CROSS: begin
                mul_a     = zr_reg;
                mul_b     = zi_reg;
                diff_next = rr_reg - prod;
            end
            ST_UPD: begin
                zr_next    = sat_re.q;
                zi_next    = sat_im.q;
                over_next  = sat_re.over || sat_im.over;
                count_next = count_reg + 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_iter_next  = ITER_W'(count_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            red_cnt_reg <= '0;
            count_reg   <= '0;
            over_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            red_cnt_reg <= red_cnt_next;
            count_reg   <= count_next;
            over_reg    <= over_next;
        end
    end

    always_ff @(posedge aclk) begin
        cre_reg    <= cre_next;
        cim_reg    <= cim_next;
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        rr_reg     <= rr_next;
        diff_reg   <= diff_next;
        m_iter_reg <= m_iter_next;
    end

endmodule

### sv/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count for one pixel: maps column/row to c in Q4.28 and
// iterates z = z*z + c until escape, overflow or the iteration limit.
//
//   channel  ports                       request
//   s_       s_valid/s_ready             s_col, s_row
//   m_       m_valid/m_ready             m_iterations
//   cfg      psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// A request passes through index reduction and point mapping, then for each
// iteration three products on the single shared 32x32 multiplier and one
// update, then a test of the last point, the hand-over of the count (held
// while the output register is full) and a return to idle.
// s_ready is high only while idle; a finished count waits in the output
// register and the next request is taken meanwhile.
// Synchronous active-low reset; configuration and control registers return to their defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int MAX_DIM   = 8192,
    parameter int ITER_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [IDX_W-1:0]   s_col,
    input  logic [IDX_W-1:0]   s_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ITER_W-1:0]  m_iterations
);

    cfg_t cfg;

    mbe_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    mbe_core #(
        .MAX_DIM   (MAX_DIM),
        .ITER_BITS (ITER_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_i        (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_col        (s_col),
        .s_row        (s_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_iterations (m_iterations)
    );

endmodule

### sv/mbe_checker.sv
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks of the escape-time block, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker
    import mbe_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [ITER_W-1:0] m_iterations
);

    // an accepted request makes the block busy
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high right after a request");

    // at least one iteration is always counted
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_iterations != '0)
        else $error("zero iteration count");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_iterations))
        else $error("stalled result changed");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);

### sim/mandelbrot_escape_time_chk.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_chk
// Passive checker for the escape-time block. It mirrors the view registers
// from the APB writes and works out the iteration count of every accepted
// pixel request. Each count leaving the block is compared in order with
// those predictions.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_chk
    import mbe_pkg::*;
#(
    parameter int MAX_DIM   = 8192,
    parameter int ITER_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [IDX_W-1:0]   s_col,
    input  logic [IDX_W-1:0]   s_row,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [ITER_W-1:0]  m_iterations,
    output int                 mismatches,
    output int                 pending,
    output int                 compared
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [Q_W-1:0]    RST_ORIGIN = 32'hE000_0000;
    localparam logic [STEP_W-1:0] RST_STEP   = 31'd214748;
    localparam logic [ITER_W-1:0] RST_ITER   = 16'd200;
    localparam logic [ESC_W-1:0]  RST_ESC    = 4'd4;
    localparam longint            Q_HI       = 64'sd2147483647;
    localparam longint            Q_LO       = -64'sd2147483648;

    typedef struct {
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
        logic [ITER_W-1:0] count;
    } pixel_count_t;

    cfg_t         view_cfg;
    pixel_count_t count_q[$];
    pixel_count_t want;
    pixel_count_t fresh;
    int           n_bad     = 0;
    int           n_checked = 0;

    function automatic longint clamp_q32(input longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    function automatic logic [ITER_W-1:0] escape_count(input logic [IDX_W-1:0] col,
                                                       input logic [IDX_W-1:0] row);
        longint      px, py, c_re, c_im, z_re, z_im, raw_re, raw_im;
        logic [63:0] mag, bound, lim, steps;
        bit          stop;
        px    = longint'(col) % MAX_DIM;
        py    = longint'(row) % MAX_DIM;
        c_re  = clamp_q32(longint'($signed(view_cfg.re_origin)) +
                          px * longint'(view_cfg.re_step));
        c_im  = clamp_q32(longint'($signed(view_cfg.im_origin)) +
                          py * longint'(view_cfg.im_step));
        lim   = 64'(view_cfg.max_iter) & ((64'd1 << ITER_BITS) - 64'd1);
        bound = 64'(view_cfg.escape_limit) << (2 * FRAC_BITS);
        z_re  = 0;
        z_im  = 0;
        steps = 0;
        do begin
            raw_re = ((z_re * z_re - z_im * z_im) >>> FRAC_BITS) + c_re;
            raw_im = ((z_re * z_im) >>> (FRAC_BITS - 1)) + c_im;
            z_re   = clamp_q32(raw_re);
            z_im   = clamp_q32(raw_im);
            // a saturated part of z counts as escaped
            stop   = (z_re != raw_re) || (z_im != raw_im);
            mag    = $unsigned(z_re * z_re) + $unsigned(z_im * z_im);
            steps++;
            if (steps >= lim || mag >= bound) stop = 1'b1;
        end while (!stop);
        return ITER_W'(steps);
    endfunction

    task automatic flag_miss(input string what);
        $display("[%0t] count mismatch: %s", $time, what);
        n_bad++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            view_cfg.re_origin    = RST_ORIGIN;
            view_cfg.im_origin    = RST_ORIGIN;
            view_cfg.re_step      = RST_STEP;
            view_cfg.im_step      = RST_STEP;
            view_cfg.max_iter     = RST_ITER;
            view_cfg.escape_limit = RST_ESC;
            count_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (count_q.size() == 0) begin
                    flag_miss($sformatf("count %0d with no request pending", m_iterations));
                end else begin
                    want = count_q.pop_front();
                    if (m_iterations !== want.count)
                        flag_miss($sformatf("pixel (%0d,%0d) gave %0d, expected %0d",
                                            want.col, want.row, m_iterations, want.count));
                    n_checked++;
                end
            end
            if (s_valid && s_ready) begin
                fresh.col   = s_col;
                fresh.row   = s_row;
                fresh.count = escape_count(s_col, s_row);
                count_q.insert(count_q.size(), fresh);
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_RE_ORIGIN: view_cfg.re_origin    = pwdata[Q_W-1:0];
                    REG_IM_ORIGIN: view_cfg.im_origin    = pwdata[Q_W-1:0];
                    REG_RE_STEP:   view_cfg.re_step      = pwdata[STEP_W-1:0];
                    REG_IM_STEP:   view_cfg.im_step      = pwdata[STEP_W-1:0];
                    REG_MAX_ITER:  view_cfg.max_iter     = pwdata[ITER_W-1:0];
                    REG_ESC_LIMIT: view_cfg.escape_limit = pwdata[ESC_W-1:0];
                    default: ;
                endcase
            end
        end
        mismatches <= n_bad;
        pending    <= count_q.size();
        compared   <= n_checked;
    end

endmodule

### sim/mandelbrot_escape_time_tb.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_tb
// Drives pixel requests and view settings into the escape-time block: a
// directed pass over corner pixels, limit values and saturating points, then
// random views with random pixels under random idling on both channels.
// Counts are checked by mandelbrot_escape_time_chk.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_tb
    import mbe_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_DIM        = 8192;
    localparam int          ITER_BITS      = 16;
    localparam int          CLK_PERIOD     = 20;
    localparam int          RANDOM_ITEMS   = 1700;
    localparam int          TAIL_CYCLES    = 300;
    // must outlast one in-set point running to the full limit
    localparam int          WATCHDOG_LIMIT = 1_100_000;
    localparam int          Q_ONE          = 1 << FRAC_BITS;
    localparam int          MAX_IDX        = (1 << IDX_W) - 1;
    localparam logic [2:0]  REG_SPARE_LO   = 3'd6;
    localparam logic [2:0]  REG_SPARE_HI   = 3'd7;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid  = 1'b0;
    logic               s_ready;
    logic [IDX_W-1:0]   s_col    = '0;
    logic [IDX_W-1:0]   s_row    = '0;
    logic               m_valid;
    logic               m_ready  = 1'b0;
    logic [ITER_W-1:0]  m_iterations;

    int mismatches, pending, compared;
    int quiet_cycles = 0;
    int sent         = 0;
    int views        = 0;
    bit idle_on      = 1'b1;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    mandelbrot_escape_time #(
        .MAX_DIM   (MAX_DIM),
        .ITER_BITS (ITER_BITS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_col        (s_col),
        .s_row        (s_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_iterations (m_iterations)
    );

    mandelbrot_escape_time_chk #(
        .MAX_DIM   (MAX_DIM),
        .ITER_BITS (ITER_BITS)
    ) i_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_col        (s_col),
        .s_row        (s_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_iterations (m_iterations),
        .mismatches   (mismatches),
        .pending      (pending),
        .compared     (compared)
    );

    always @(posedge aclk) begin
        m_ready <= idle_on ? ($urandom_range(0, 99) >= 24) : 1'b1;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $time, quiet_cycles);
            $display("mandelbrot_escape_time test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_view(input logic [31:0] re_o, input logic [31:0] im_o,
                             input logic [31:0] re_s, input logic [31:0] im_s,
                             input logic [31:0] iters, input logic [31:0] esc);
        apb_write(REG_RE_ORIGIN, re_o);
        apb_write(REG_IM_ORIGIN, im_o);
        apb_write(REG_RE_STEP, re_s);
        apb_write(REG_IM_STEP, im_s);
        apb_write(REG_MAX_ITER, iters);
        apb_write(REG_ESC_LIMIT, esc);
        views++;
    endtask

    task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        while (idle_on && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_col   <= col;
        s_row   <= row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    // block is idle once every request has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // random junk above the register field, in about one call of three
    function automatic logic [31:0] dirty_upper(input logic [31:0] v, input int w);
        logic [31:0] keep_mask;
        keep_mask = (32'h1 << w) - 32'h1;
        if ($urandom_range(0, 2) != 0) return v;
        return (v & keep_mask) | ($urandom & ~keep_mask);
    endfunction

    initial begin
        int               w, h, r, n_items, phase, random_sent;
        logic [31:0]      re_o, im_o, re_s, im_s, iters, esc;
        logic [IDX_W-1:0] col, row;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset view: corners, bit patterns, an in-set pixel near the origin
        send_pixel(0, 0);
        send_pixel(MAX_IDX, MAX_IDX);
        send_pixel(0, MAX_IDX);
        send_pixel(MAX_IDX, 0);
        send_pixel(13'h1555, 13'h0AAA);
        send_pixel(13'h0AAA, 13'h1555);
        send_pixel(2500, 2500);

        // zero iteration limit and zero escape bound
        drain();
        load_view(0, 0, 0, 0, 0, 0);
        send_pixel(0, 0);
        send_pixel(MAX_IDX, MAX_IDX);

        // point saturates at the top bound
        drain();
        load_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 15);
        send_pixel(MAX_IDX, MAX_IDX);
        send_pixel(1, 0);

        // most negative corner
        drain();
        load_view(32'h8000_0000, 32'h8000_0000, 0, 0, 32'hFFFF, 15);
        send_pixel(0, 0);

        // z overflows on the second iteration; spare addresses change nothing
        drain();
        load_view(3 * Q_ONE, 0, 0, 0, 100, 15);
        send_pixel(0, 0);
        drain();
        apb_write(REG_SPARE_LO, $urandom);
        apb_write(REG_SPARE_HI, $urandom);
        send_pixel(7, 9);

        // c = 0 never escapes: runs the full 16-bit limit
        drain();
        load_view(0, 0, 0, 0, 32'hFFFF, 4);
        send_pixel(5, 7);

        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            idle_on <= !(phase >= 4 && phase < 8);
            w = $urandom_range(1, MAX_IDX);
            h = $urandom_range(1, MAX_IDX);
            if ($urandom_range(0, 9) < 8) begin
                re_o = 32'(-(5 * Q_ONE / 2) + int'($urandom_range(0, 3 * Q_ONE)));
                im_o = 32'(-(3 * Q_ONE / 2) + int'($urandom_range(0, 2 * Q_ONE)));
            end else begin
                re_o = $urandom;
                im_o = $urandom;
            end
            if ($urandom_range(0, 99) < 85) begin
                re_s = $urandom_range(Q_ONE / 64, 3 * Q_ONE) / w;
                im_s = $urandom_range(Q_ONE / 64, 3 * Q_ONE) / h;
            end else begin
                re_s = $urandom;
                im_s = $urandom;
            end
            r = $urandom_range(0, 99);
            if (r < 8)       iters = $urandom_range(0, 1);
            else if (r < 80) iters = $urandom_range(2, 48);
            else if (r < 95) iters = $urandom_range(49, 255);
            else             iters = $urandom_range(256, 1023);
            esc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15);

            drain();
            load_view(re_o, im_o, dirty_upper(re_s, STEP_W), dirty_upper(im_s, STEP_W),
                      dirty_upper(iters, ITER_W), dirty_upper(esc, ESC_W));
            n_items = $urandom_range(40, 110);
            repeat (n_items) begin
                col = ($urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, w - 1))
                                                   : IDX_W'($urandom);
                row = ($urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, h - 1))
                                                   : IDX_W'($urandom);
                send_pixel(col, row);
                random_sent++;
            end
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d pixel requests over %0d view settings, %0d counts compared",
                 sent, views, compared);
        $display("covered limits 0 to 65535, escape bounds 0 to 15, saturated points");
        if (mismatches == 0 && pending == 0) begin
            $display("mandelbrot_escape_time test passed");
        end else begin
            $display("mandelbrot_escape_time test failed");
        end
        $finish;
    end

endmodule
